// File: rtl/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

  // error codes reported with a result word
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SHORT_FIRST = 3'd1,
    ERR_SHORT_CONT  = 3'd2,
    ERR_BAD_SEQ     = 3'd3,
    ERR_OVERFLOW    = 3'd4
  } err_code_t;

  // position within a link frame: header bytes, then payload
  typedef enum logic [1:0] {
    POS_CMD     = 2'd0,
    POS_LEN_HI  = 2'd1,
    POS_LEN_LO  = 2'd2,
    POS_PAYLOAD = 2'd3
  } frame_pos_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned SEQ_W  = 7;

endpackage

`default_nettype wire

// File: rtl/ble_frame_reassembler_core.sv
`default_nettype none

// Byte-serial reassembler for framed messages arriving over a packet radio link.
// Each input word is one received byte plus a flag on the last byte of its link
// frame. A first frame carries a command byte and a 16-bit big-endian length,
// and every later frame opens with a 7-bit sequence byte checked against a
// counter that restarts with each message. Payload bytes leave one per result
// word with their offset in the message; completion and the four errors (short
// first frame, short continuation, bad sequence, overflow) are flagged on a
// result word too. Header bytes and bytes discarded after an error give no
// result. Throughput is one byte per clock when no result is held by out_stall:
// the whole frame-state update is a combinational loop between the input
// register and the state registers. An accepted byte is held in the input
// register and its result is then registered in the output register. A result
// held by out_stall stalls the input once the input register is also occupied.
module ble_frame_reassembler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_end,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_byte_offset,
  output logic [7:0]       out_message_cmd,
  output logic [15:0]      out_message_length,
  output logic             out_message_done,
  output logic [2:0]       out_error_code
);

  // input register
  logic                           in_full_r;
  logic [bfr_pkg::BYTE_W-1:0]     rx_r;
  logic                           last_r;

  // frame state
  logic                           expect_first_r, expect_first_nxt;
  bfr_pkg::frame_pos_t            frame_pos_r, frame_pos_nxt;
  logic [bfr_pkg::BYTE_W-1:0]     cmd_r, cmd_nxt;
  logic [bfr_pkg::LEN_W-1:0]      length_r, length_nxt;
  logic [bfr_pkg::LEN_W-1:0]      offset_r, offset_nxt;
  logic [bfr_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic                           discarding_r, discarding_nxt;

  // output register
  logic                           out_valid_r;
  logic                           out_pay_r;
  logic [bfr_pkg::BYTE_W-1:0]     out_byte_r;
  logic [bfr_pkg::LEN_W-1:0]      out_off_r;
  logic [bfr_pkg::BYTE_W-1:0]     out_cmd_r;
  logic [bfr_pkg::LEN_W-1:0]      out_len_r;
  logic                           out_done_r;
  bfr_pkg::err_code_t             out_err_r;

  // decode of the held byte
  bfr_pkg::err_code_t             err;
  logic                           pay;
  logic                           done;
  logic                           has_result;
  logic [bfr_pkg::LEN_W-1:0]      offset_inc;
  logic [bfr_pkg::LEN_W-1:0]      length_full;

  logic                           out_free;
  logic                           proc;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  // held byte is processed whenever its result can be stored
  assign proc     = in_full_r && out_free;
  assign in_stall = in_full_r && !out_free;

  assign offset_inc  = offset_r + {{(bfr_pkg::LEN_W-1){1'b0}}, 1'b1};
  // low length byte is still zero while the low header byte is arriving
  assign length_full = {length_r[bfr_pkg::LEN_W-1:bfr_pkg::BYTE_W], rx_r};

  // classify the held byte: payload, completion, error
  always_comb begin
    err  = bfr_pkg::ERR_NONE;
    pay  = 1'b0;
    done = 1'b0;
    if (!discarding_r) begin
      if (frame_pos_r == bfr_pkg::POS_PAYLOAD) begin
        if (offset_r >= length_r) begin
          err = bfr_pkg::ERR_OVERFLOW;
        end else begin
          pay  = 1'b1;
          done = last_r && (offset_inc == length_r);
        end
      end else if (expect_first_r) begin
        unique case (frame_pos_r)
          bfr_pkg::POS_CMD,
          bfr_pkg::POS_LEN_HI: begin
            if (last_r) err = bfr_pkg::ERR_SHORT_FIRST;
          end
          bfr_pkg::POS_LEN_LO: begin
            done = last_r && (length_full == '0);
          end
          default: begin
          end
        endcase
      end else begin
        // continuation frame: sequence byte
        if (last_r) begin
          err = bfr_pkg::ERR_SHORT_CONT;
        end else if (rx_r != {1'b0, seq_r}) begin
          // top bit set never matches
          err = bfr_pkg::ERR_BAD_SEQ;
        end
      end
    end
  end

  // next frame state
  always_comb begin
    expect_first_nxt = expect_first_r;
    frame_pos_nxt    = frame_pos_r;
    cmd_nxt          = cmd_r;
    length_nxt       = length_r;
    offset_nxt       = offset_r;
    seq_nxt          = seq_r;
    discarding_nxt   = discarding_r;
    if (discarding_r) begin
      if (last_r) begin
        discarding_nxt = 1'b0;
        frame_pos_nxt  = bfr_pkg::POS_CMD;
      end
    end else begin
      if (frame_pos_r == bfr_pkg::POS_PAYLOAD) begin
        if (pay) begin
          offset_nxt = offset_inc;
          if (last_r) frame_pos_nxt = bfr_pkg::POS_CMD;
          if (done) expect_first_nxt = 1'b1;
        end
      end else if (expect_first_r) begin
        unique case (frame_pos_r)
          bfr_pkg::POS_CMD: begin
            cmd_nxt       = rx_r;
            length_nxt    = '0;
            offset_nxt    = '0;
            seq_nxt       = '0;
            frame_pos_nxt = bfr_pkg::POS_LEN_HI;
          end
          bfr_pkg::POS_LEN_HI: begin
            length_nxt    = {rx_r, {bfr_pkg::BYTE_W{1'b0}}};
            frame_pos_nxt = bfr_pkg::POS_LEN_LO;
          end
          bfr_pkg::POS_LEN_LO: begin
            length_nxt       = length_full;
            expect_first_nxt = done;
            frame_pos_nxt    = last_r ? bfr_pkg::POS_CMD : bfr_pkg::POS_PAYLOAD;
          end
          default: begin
          end
        endcase
      end else if (err == bfr_pkg::ERR_NONE) begin
        seq_nxt       = seq_r + {{(bfr_pkg::SEQ_W-1){1'b0}}, 1'b1};
        frame_pos_nxt = bfr_pkg::POS_PAYLOAD;
      end
      // any error: back to waiting for a first frame, drop rest of frame
      if (err != bfr_pkg::ERR_NONE) begin
        expect_first_nxt = 1'b1;
        frame_pos_nxt    = bfr_pkg::POS_CMD;
        discarding_nxt   = !last_r;
      end
    end
  end

  assign has_result = pay || done || (err != bfr_pkg::ERR_NONE);

  // input register: load whenever the slot is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (!in_stall) begin
      in_full_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      rx_r   <= in_rx_byte;
      last_r <= in_frame_end;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_first_r <= 1'b1;
      frame_pos_r    <= bfr_pkg::POS_CMD;
      cmd_r          <= '0;
      length_r       <= '0;
      offset_r       <= '0;
      seq_r          <= '0;
      discarding_r   <= 1'b0;
    end else if (proc) begin
      expect_first_r <= expect_first_nxt;
      frame_pos_r    <= frame_pos_nxt;
      cmd_r          <= cmd_nxt;
      length_r       <= length_nxt;
      offset_r       <= offset_nxt;
      seq_r          <= seq_nxt;
      discarding_r   <= discarding_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && has_result;
    end
    if (proc && has_result) begin
      out_pay_r  <= pay;
      out_byte_r <= pay ? rx_r : '0;
      out_off_r  <= pay ? offset_r : '0;
      // short first frame reports no header fields
      out_cmd_r  <= (err == bfr_pkg::ERR_SHORT_FIRST) ? '0 : cmd_nxt;
      out_len_r  <= (err == bfr_pkg::ERR_SHORT_FIRST) ? '0 : length_nxt;
      out_done_r <= done;
      out_err_r  <= err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = out_pay_r;
  assign out_payload_byte   = out_byte_r;
  assign out_byte_offset    = out_off_r;
  assign out_message_cmd    = out_cmd_r;
  assign out_message_length = out_len_r;
  assign out_message_done   = out_done_r;
  assign out_error_code     = out_err_r;

`ifndef SYNTHESIS
  a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_err_r == bfr_pkg::ERR_NONE)
    else $error("completion reported together with an error");

  a_pay_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pay_r |-> out_err_r == bfr_pkg::ERR_NONE)
    else $error("payload byte passed on together with an error");

  a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pay_r |-> out_off_r < out_len_r)
    else $error("payload offset beyond declared length");

  a_discard_state: assert property (@(posedge clk) disable iff (!rst_n)
    discarding_r |-> expect_first_r && frame_pos_r == bfr_pkg::POS_CMD)
    else $error("discarding while not waiting for a first frame");

  a_err_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && err != bfr_pkg::ERR_NONE |=>
      expect_first_r && frame_pos_r == bfr_pkg::POS_CMD)
    else $error("error did not return to first-frame wait");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected or observed result word, packed so it compares in one go
  typedef struct packed {
    logic                pv;
    logic [7:0]          pb;
    logic [15:0]         off;
    logic [7:0]          cmd;
    logic [15:0]         len;
    logic                done;
    bfr_pkg::err_code_t  err;
  } msg_word_t;

  // one entry of the send queue: a received byte, or a marker that holds
  // the sender back until every outstanding result has come out
  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       hold;
  } rx_entry_t;

  // ways a generated message can be broken
  typedef enum int {
    MSG_CLEAN,
    MSG_SHORT_FIRST,
    MSG_SHORT_CONT,
    MSG_BAD_SEQ,
    MSG_OVERFLOW,
    MSG_CUT
  } msg_fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_offset;
  logic [7:0]  out_message_cmd;
  logic [15:0] out_message_length;
  logic        out_message_done;
  logic [2:0]  out_error_code;

  ble_frame_reassembler_core dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_rx_byte,
    .in_frame_end,
    .out_valid,
    .out_stall,
    .out_payload_valid,
    .out_payload_byte,
    .out_byte_offset,
    .out_message_cmd,
    .out_message_length,
    .out_message_done,
    .out_error_code
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_entry_t tx_bytes[$];
  msg_word_t pending_results[$];
  int        bytes_queued = 0;
  int        bytes_taken = 0;
  int        mismatches = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        calm_left = 0;

  // reassembler state as the predictor sees it
  logic                 want_first;
  bfr_pkg::frame_pos_t  fpos;
  logic [7:0]           cmd_q;
  logic [15:0]          len_q;
  logic [15:0]          off_q;
  logic [6:0]           seq_q;
  logic                 dropping;

  task automatic reset_reassembly();
    want_first = 1'b1;
    fpos = bfr_pkg::POS_CMD;
    cmd_q = 8'h00;
    len_q = 16'h0000;
    off_q = 16'h0000;
    seq_q = 7'h00;
    dropping = 1'b0;
  endtask

  // advance the predicted frame state by one accepted byte and queue the
  // result word it gives, if any
  task automatic reassemble_byte(input logic [7:0] rx, input logic last);
    msg_word_t r;
    r = '0;
    r.err = bfr_pkg::ERR_NONE;
    // rest of a frame that already failed: swallow up to its end
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        fpos = bfr_pkg::POS_CMD;
      end
      return;
    end
    if (fpos == bfr_pkg::POS_PAYLOAD) begin
      if (off_q >= len_q) begin
        // more payload than the header declared
        r.err = bfr_pkg::ERR_OVERFLOW;
      end else begin
        r.pv = 1'b1;
        r.pb = rx;
        r.off = off_q;
        off_q = off_q + 16'd1;
        if (last) begin
          fpos = bfr_pkg::POS_CMD;
          if (off_q == len_q) begin
            r.done = 1'b1;
            want_first = 1'b1;
          end
        end
      end
    end else if (want_first) begin
      case (fpos)
        bfr_pkg::POS_CMD: begin
          cmd_q = rx;
          len_q = 16'h0000;
          off_q = 16'h0000;
          seq_q = 7'h00;
          if (last) r.err = bfr_pkg::ERR_SHORT_FIRST;
          else fpos = bfr_pkg::POS_LEN_HI;
        end
        bfr_pkg::POS_LEN_HI: begin
          len_q = {rx, 8'h00};
          if (last) r.err = bfr_pkg::ERR_SHORT_FIRST;
          else fpos = bfr_pkg::POS_LEN_LO;
        end
        default: begin
          len_q = len_q | {8'h00, rx};
          want_first = 1'b0;
          fpos = bfr_pkg::POS_PAYLOAD;
          if (last) begin
            fpos = bfr_pkg::POS_CMD;
            // zero-length message completes on the bare header
            if (len_q == 16'h0000) begin
              r.done = 1'b1;
              want_first = 1'b1;
            end
          end
        end
      endcase
    end else begin
      // sequence byte of a continuation frame; a short frame wins over a
      // mismatch, and a set top bit never matches the 7-bit counter
      if (last) r.err = bfr_pkg::ERR_SHORT_CONT;
      else if (rx != {1'b0, seq_q}) r.err = bfr_pkg::ERR_BAD_SEQ;
      else begin
        seq_q = seq_q + 7'd1;
        fpos = bfr_pkg::POS_PAYLOAD;
      end
    end
    if (r.err != bfr_pkg::ERR_NONE) begin
      want_first = 1'b1;
      fpos = bfr_pkg::POS_CMD;
      dropping = !last;
    end
    if (r.pv || r.done || r.err != bfr_pkg::ERR_NONE) begin
      r.cmd = (r.err == bfr_pkg::ERR_SHORT_FIRST) ? 8'h00 : cmd_q;
      r.len = (r.err == bfr_pkg::ERR_SHORT_FIRST) ? 16'h0000 : len_q;
      pending_results.push_back(r);
    end
  endtask

  // pacing: now and then a calm stretch with no gaps and no new stalls
  always @(posedge clk) begin
    if (!rst_n) calm_left <= 0;
    else if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(30, 150);
  end

  // mostly short pauses, a few long ones
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic int pick_gap();
    if (calm_left > 0) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  // one result word as text
  function automatic string fmt_word(input msg_word_t w);
    return $sformatf("pv=%0b byte=%02h off=%0d cmd=%02h len=%0d done=%0b err=%0d",
                     w.pv, w.pb, w.off, w.cmd, w.len, w.done, w.err);
  endfunction

  // driver: takes the next byte off the send queue whenever the current
  // word has gone or none is on offer; predicts each word as it is taken
  always @(posedge clk) begin : drive
    rx_entry_t e;
    logic      nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        reassemble_byte(in_rx_byte, in_frame_end);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (tx_bytes.size() > 0) begin
          if (tx_bytes[0].hold) begin
            // hold back until the block has handed over every result
            if (pending_results.size() == 0) void'(tx_bytes.pop_front());
          end else begin
            e = tx_bytes.pop_front();
            in_rx_byte <= e.b;
            in_frame_end <= e.last;
            nv = 1'b1;
            gap_left = pick_gap();
          end
        end
        in_valid <= nv;
      end
    end
  end

  // receiver back-pressure, independent of out_valid
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
      stall_left = pick_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: every word taken off the result channel against the oldest
  // prediction
  always @(posedge clk) begin : watch
    msg_word_t got;
    msg_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.pv = out_payload_valid;
      got.pb = out_payload_byte;
      got.off = out_byte_offset;
      got.cmd = out_message_cmd;
      got.len = out_message_length;
      got.done = out_message_done;
      got.err = bfr_pkg::err_code_t'(out_error_code);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, actual %s",
                 $time, fmt_word(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch, expected %s", $time, fmt_word(want));
          $display("%0t:          actual %s", $time, fmt_word(got));
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    rx_entry_t e;
    e.b = b;
    e.last = last;
    e.hold = 1'b0;
    tx_bytes.push_back(e);
    bytes_queued++;
  endtask

  task automatic push_drain();
    rx_entry_t e;
    e.b = 8'h00;
    e.last = 1'b0;
    e.hold = 1'b1;
    tx_bytes.push_back(e);
  endtask

  // n random payload bytes, the last of them closing the frame
  task automatic push_payload(input int n);
    int i;
    for (i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endtask

  // one message cut into link frames of at most mtu bytes, optionally broken
  task automatic send_message(input logic [7:0] cmd, input int len, input int mtu,
                              input msg_fault_t fault);
    int         sent;
    int         n;
    int         tail;
    int         extra;
    int         frames;
    int         fault_frame;
    int         i;
    logic [6:0] seq;
    logic [7:0] sb;
    extra = (fault == MSG_OVERFLOW) ? $urandom_range(1, 3) : 0;
    fault_frame = $urandom_range(0, 3);
    if (fault == MSG_SHORT_FIRST) begin
      if ($urandom_range(0, 1)) begin
        push_byte(cmd, 1'b1);
      end else begin
        push_byte(cmd, 1'b0);
        push_byte(8'(len >> 8), 1'b1);
      end
      return;
    end
    // first frame: command, length high, length low, then payload
    n = (len < mtu - 3) ? len : mtu - 3;
    tail = (n == len) ? extra : 0;
    push_byte(cmd, 1'b0);
    push_byte(8'(len >> 8), 1'b0);
    push_byte(8'(len), (n + tail) == 0);
    push_payload(n + tail);
    sent = n;
    seq = 7'h00;
    frames = 0;
    // continuation frames: sequence byte, then payload
    while (sent < len) begin
      if (frames == fault_frame) begin
        case (fault)
          MSG_SHORT_CONT: begin
            push_byte({1'b0, seq}, 1'b1);
            return;
          end
          MSG_BAD_SEQ: begin
            if ($urandom_range(0, 1)) sb = {1'b1, seq};
            else sb = {1'b0, seq + 7'($urandom_range(1, 127))};
            push_byte(sb, 1'b0);
            for (i = $urandom_range(0, 3); i > 0; i--) push_byte(8'($urandom), 1'b0);
            push_byte(8'($urandom), 1'b1);
            return;
          end
          MSG_CUT: return;
          default: ;
        endcase
      end
      push_byte({1'b0, seq}, 1'b0);
      n = (len - sent < mtu - 1) ? len - sent : mtu - 1;
      tail = (sent + n == len) ? extra : 0;
      push_payload(n + tail);
      sent += n;
      seq = seq + 7'd1;
      frames++;
    end
  endtask

  // loose bytes with random frame ends, closed by a frame end
  task automatic send_noise();
    int k;
    int i;
    k = $urandom_range(1, 8);
    for (i = 0; i < k; i++)
      push_byte(8'($urandom), (i == k - 1) || ($urandom_range(0, 3) == 0));
  endtask

  // safety net against a hung handshake
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int         r;
    int         len;
    reset_reassembly();

    // directed: zero-length message on a bare three-byte header
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // short first frame, ending on the command byte and on the length high byte
    push_byte(8'h00, 1'b1);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h5a, 1'b1);
    // clean three-byte message over two frames
    push_byte(8'h81, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);
    // largest declared length, then a continuation that is only its sequence byte
    push_byte(8'h3c, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b1);
    // sequence byte with its top bit set, rest of the frame thrown away
    push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b1);
    // overflow: one byte declared, three sent in the same frame
    push_byte(8'h7e, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b1);
    push_drain();

    // long message in tiny frames so the sequence counter wraps
    send_message(8'($urandom), 280, 3, MSG_CLEAN);
    push_drain();

    while (bytes_queued < 1750) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (len < 85) len = $urandom_range(0, 24);
      else if (len < 97) len = $urandom_range(25, 120);
      else len = $urandom_range(121, 400);
      if (r < 68) send_message(8'($urandom), len, $urandom_range(3, 23), MSG_CLEAN);
      else if (r < 90)
        send_message(8'($urandom), len, $urandom_range(3, 23),
                     msg_fault_t'($urandom_range(1, 5)));
      else send_noise();
      if ($urandom_range(0, 99) == 0) push_drain();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every byte handed over, then every result out, then a short tail
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bfr_pkg.sv
rtl/ble_frame_reassembler_core.sv
bench/tb_top.sv
